// File: src/scf_pkg.sv
// Package for the stream channel FIFO: sizes, operation and result codes,
// controller states and the structs shared between modules. No dependencies.
package scf_pkg;

  // Number of FIFO slots; pointers carry one extra wrap bit.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned PTR_W = IDX_W + 1;

  // Fixed field widths of the channel words.
  localparam int unsigned DATA_W = 64;
  localparam int unsigned FILL_W = 5;
  localparam int unsigned CNT_W  = 32;

  // Configuration register indexes and address width.
  localparam int unsigned PADDR_W = 4;
  localparam logic [1:0] REG_CHAN_MODE  = 2'd0;
  localparam logic [1:0] REG_BLOCK_FULL = 2'd1;
  localparam logic [1:0] REG_FINITE     = 2'd2;

  // Ring modes that the block supports.
  localparam logic [1:0] MODE_SINGLE      = 2'd0;
  localparam logic [1:0] MODE_MULTI_CONS  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUT          = 3'd0,
    OP_POLL         = 3'd1,
    OP_OPEN         = 3'd2,
    OP_CLOSE        = 3'd3,
    OP_CLOSE_STREAM = 3'd4,
    OP_CANCEL       = 3'd5
  } scf_op_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_NOT_OPEN    = 3'd2,
    ST_CANCELLED   = 3'd3,
    ST_DROPPED     = 3'd4,
    ST_RETRY       = 3'd5,
    ST_EOF_NQ      = 3'd6
  } scf_status_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_DATA    = 3'd1,
    EV_EOF     = 3'd2,
    EV_DRAINED = 3'd3,
    EV_TIMEOUT = 3'd4,
    EV_ERROR   = 3'd5
  } scf_event_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } scf_state_e;

  // Configuration register contents.
  typedef struct packed {
    logic [1:0] chan_mode;
    logic       block_when_full;
    logic       finite_stream;
  } scf_cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic execute;
  } scf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_stall;
  } scf_stat_t;

endpackage

// File: src/scf_if.sv
// Valid/ready stream interfaces for the input and result channels.
// Depends on scf_pkg for the field widths.
interface scf_in_if;
  import scf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               opcode;
  logic [DATA_W-1:0]        payload;
  logic signed [DATA_W-1:0] timestamp;
  modport source (output valid, opcode, payload, timestamp, input ready);
  modport sink   (input valid, opcode, payload, timestamp, output ready);
endinterface

interface scf_out_if;
  import scf_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [2:0]               event_res;
  logic [DATA_W-1:0]        out_payload;
  logic signed [DATA_W-1:0] out_timestamp;
  logic [FILL_W-1:0]        fill_level;
  logic [CNT_W-1:0]         dropped_count;
  modport source (output valid, status, event_res, out_payload, out_timestamp,
                  fill_level, dropped_count, input ready);
  modport sink   (input valid, status, event_res, out_payload, out_timestamp,
                  fill_level, dropped_count, output ready);
endinterface

// File: src/scf_regs.sv
// APB-style configuration registers of the stream channel FIFO.
// Depends on scf_pkg for register indexes and the configuration struct.
module scf_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scf_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output scf_pkg::scf_cfg_t             cfg_o
);
  import scf_pkg::*;

  scf_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode; addresses past the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_CHAN_MODE:  cfg_d.chan_mode       = pwdata[1:0];
        REG_BLOCK_FULL: cfg_d.block_when_full = pwdata[0];
        REG_FINITE:     cfg_d.finite_stream   = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{chan_mode: 2'd0, block_when_full: 1'b0, finite_stream: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back.
  always_comb begin
    unique case (paddr[3:2])
      REG_CHAN_MODE:  prdata = {30'd0, cfg_q.chan_mode};
      REG_BLOCK_FULL: prdata = {31'd0, cfg_q.block_when_full};
      REG_FINITE:     prdata = {31'd0, cfg_q.finite_stream};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// File: src/scf_ctrl.sv
// Controller state machine of the stream channel FIFO: accepts a word,
// then executes it once the result register can take the answer.
// Depends on scf_pkg for the state enum and command/status structs.
module scf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  scf_pkg::scf_stat_t stat_i,
  output scf_pkg::scf_cmd_t  cmd_o
);
  import scf_pkg::*;

  scf_state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (!stat_i.out_stall) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.execute = !stat_i.out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/scf_dp.sv
// Datapath of the stream channel FIFO: slot memory, pointers, channel flags,
// drop counter and the result register. Depends on scf_pkg and scf_out_if.
module scf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scf_pkg::scf_cmd_t                 cmd_i,
  output scf_pkg::scf_stat_t                stat_o,
  input  scf_pkg::scf_cfg_t                 cfg_i,
  input  logic [2:0]                        opcode_i,
  input  logic [scf_pkg::DATA_W-1:0]        payload_i,
  input  logic signed [scf_pkg::DATA_W-1:0] timestamp_i,
  scf_out_if.source                         out_o
);
  import scf_pkg::*;

  localparam int unsigned SLOT_W = 2 * DATA_W + 1;

  // Captured input word.
  logic [2:0]        op_q;
  logic [DATA_W-1:0] pay_q;
  logic [DATA_W-1:0] ts_q;

  // Slot memory: {eof mark, payload, timestamp}; read data registered.
  logic [SLOT_W-1:0] mem [DEPTH];
  logic [SLOT_W-1:0] rd_q;

  // Pointers and channel state.
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic             open_q, open_d, fin_q, fin_d, cancel_q, cancel_d;
  logic             cs_done_q, cs_done_d, cn_done_q, cn_done_d;
  logic [CNT_W-1:0] drop_q, drop_d;

  // Result register.
  logic              ovalid_q;
  logic [2:0]        ost_q, oev_q;
  logic [DATA_W-1:0] opay_q, ots_q;
  logic [FILL_W-1:0] ofill_q;

  // Step results.
  scf_status_e       st;
  scf_event_e        ev;
  logic [DATA_W-1:0] opay, ots;
  logic              push, push_eof, pop;
  logic [PTR_W-1:0]  fill, fill_next;
  logic              mode_ok, full;

  assign stat_o.out_stall = ovalid_q & ~out_o.ready;

  assign mode_ok = (cfg_i.chan_mode == MODE_SINGLE) || (cfg_i.chan_mode == MODE_MULTI_CONS);
  assign fill    = wr_ptr_q - rd_ptr_q;
  assign full    = (fill == PTR_W'(DEPTH));

  // Capture the accepted word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= opcode_i;
      pay_q <= payload_i;
      ts_q  <= timestamp_i;
    end
  end

  // Operation decode.
  always_comb begin
    st        = ST_OK;
    ev        = EV_NONE;
    opay      = '0;
    ots       = '0;
    push      = 1'b0;
    push_eof  = 1'b0;
    pop       = 1'b0;
    open_d    = open_q;
    fin_d     = fin_q;
    cancel_d  = cancel_q;
    cs_done_d = cs_done_q;
    cn_done_d = cn_done_q;
    drop_d    = drop_q;
    unique case (op_q)
      OP_PUT: begin
        if (!mode_ok) begin
          st = ST_UNSUPPORTED;
        end else if (!open_q) begin
          st = ST_NOT_OPEN;
        end else if (cancel_q) begin
          st = ST_CANCELLED;
        end else if (full) begin
          if (cfg_i.block_when_full && cfg_i.finite_stream) begin
            st = ST_RETRY;
          end else begin
            st = ST_DROPPED;
            if (drop_q != '1) drop_d = drop_q + 1'b1;
          end
        end else begin
          push = 1'b1;
        end
      end
      OP_POLL: begin
        if (!mode_ok) begin
          st = ST_UNSUPPORTED;
          ev = EV_ERROR;
        end else if (fill != '0) begin
          pop = 1'b1;
          if (rd_q[SLOT_W-1]) begin
            ev = EV_EOF;
          end else begin
            ev   = EV_DATA;
            opay = rd_q[2*DATA_W-1:DATA_W];
            ots  = rd_q[DATA_W-1:0];
          end
        end else if (cancel_q && fin_q) begin
          ev = EV_DRAINED;
        end else if (fin_q) begin
          ev = EV_EOF;
        end else begin
          ev = EV_TIMEOUT;
        end
      end
      OP_OPEN: begin
        if (!mode_ok) begin
          st = ST_UNSUPPORTED;
        end else begin
          open_d   = 1'b1;
          fin_d    = 1'b0;
          cancel_d = 1'b0;
        end
      end
      OP_CLOSE: begin
        open_d = 1'b0;
        fin_d  = 1'b1;
      end
      OP_CLOSE_STREAM, OP_CANCEL: begin
        if ((op_q == OP_CLOSE_STREAM) ? !cs_done_q : !cn_done_q) begin
          if (op_q == OP_CLOSE_STREAM) begin
            cs_done_d = 1'b1;
          end else begin
            cn_done_d = 1'b1;
            cancel_d  = 1'b1;
          end
          fin_d = 1'b1;
          if (!mode_ok) begin
            st = ST_UNSUPPORTED;
          end else if (full) begin
            st = ST_EOF_NQ;
          end else begin
            push     = 1'b1;
            push_eof = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  assign wr_ptr_d  = wr_ptr_q + PTR_W'(push);
  assign rd_ptr_d  = rd_ptr_q + PTR_W'(pop);
  assign fill_next = wr_ptr_d - rd_ptr_d;

  // Slot memory write and registered read at the read pointer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && push) begin
      mem[wr_ptr_q[IDX_W-1:0]] <= push_eof ? {1'b1, {(2*DATA_W){1'b0}}}
                                           : {1'b0, pay_q, ts_q};
    end
    rd_q <= mem[rd_ptr_q[IDX_W-1:0]];
  end

  // Channel state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      open_q    <= 1'b0;
      fin_q     <= 1'b0;
      cancel_q  <= 1'b0;
      cs_done_q <= 1'b0;
      cn_done_q <= 1'b0;
      drop_q    <= '0;
    end else if (cmd_i.execute) begin
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      open_q    <= open_d;
      fin_q     <= fin_d;
      cancel_q  <= cancel_d;
      cs_done_q <= cs_done_d;
      cn_done_q <= cn_done_d;
      drop_q    <= drop_d;
    end
  end

  // Result word valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.execute) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  // Result word payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      ost_q   <= st;
      oev_q   <= ev;
      opay_q  <= opay;
      ots_q   <= ots;
      ofill_q <= FILL_W'(fill_next);
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = ost_q;
  assign out_o.event_res     = oev_q;
  assign out_o.out_payload   = opay_q;
  assign out_o.out_timestamp = ots_q;
  assign out_o.fill_level    = ofill_q;
  assign out_o.dropped_count = drop_q;

endmodule

// File: src/stream_channel_fifo_unit.sv
// Top level of the stream channel FIFO: configuration registers, controller
// and datapath. Depends on scf_pkg, scf_if, scf_regs, scf_ctrl and scf_dp.
//
// Usage:
//   in_i carries command words (put, poll, open, close, close stream,
//   cancel) with a payload handle and a timestamp; out_o returns one result
//   word per command: status, poll event, polled data, fill level and the
//   saturating drop count. Channels move a word when valid and ready are
//   both high. The APB port sets channel mode, block policy and finite
//   stream; the user must write them only while the block is idle, as
//   the block itself does not enforce it.
//   A taken command is captured, then executes in the controller's
//   execute step once the result register is free, and its result word
//   turns valid in the result register. The controller alternates accept
//   and execute steps around the registered slot memory read, so it
//   takes a new command only after the last has executed, also while
//   its result word still waits; a stalled receiver thus holds the block
//   after at most one further command.
//   Reset empties the FIFO, closes the channel, clears the once-only
//   flags and drop count, and loads channel mode 0, drop policy, finite stream.
module stream_channel_fifo_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  scf_in_if.sink                      in_i,
  scf_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import scf_pkg::*;

  scf_cfg_t  cfg;
  scf_cmd_t  cmd;
  scf_stat_t stat;

  scf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  scf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_i       (cfg),
    .opcode_i    (in_i.opcode),
    .payload_i   (in_i.payload),
    .timestamp_i (in_i.timestamp),
    .out_o       (out_o)
  );

endmodule

// File: verif/stream_channel_fifo_unit_tb.sv
// Self-checking testbench for stream_channel_fifo_unit: directed and random
// command words with a built-in channel predictor and a result checker.
// Depends on scf_pkg, scf_if and the RTL of the block.
module stream_channel_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scf_pkg::*;

  // Expected contents of one result word.
  typedef struct {
    scf_status_e       status;
    scf_event_e        ev;
    logic [DATA_W-1:0] payload;
    logic [DATA_W-1:0] stamp;
    logic [FILL_W-1:0] fill;
    logic [CNT_W-1:0]  drops;
  } chan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  scf_in_if  in_ch ();
  scf_out_if out_ch ();

  stream_channel_fifo_unit u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Channel state as the block should hold it, plus its register copies.
  logic [DATA_W-1:0] slot_payload [DEPTH];
  logic [DATA_W-1:0] slot_stamp [DEPTH];
  logic              slot_eof [DEPTH];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;
  logic              chan_open = 1'b0;
  logic              finished = 1'b0;
  logic              cancelled = 1'b0;
  logic              close_stream_done = 1'b0;
  logic              cancel_done = 1'b0;
  logic [CNT_W-1:0]  drop_total = '0;
  logic [1:0]        cfg_mode = MODE_SINGLE;
  logic              cfg_block = 1'b0;
  logic              cfg_finite = 1'b1;

  chan_result_t pending_results [$];
  int error_count = 0;
  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int hold_left = 0;

  function automatic logic mode_usable();
    return cfg_mode == MODE_SINGLE || cfg_mode == MODE_MULTI_CONS;
  endfunction

  function automatic logic [FILL_W-1:0] fill_now();
    logic [PTR_W-1:0] diff;
    diff = wr_ptr - rd_ptr;
    return diff;
  endfunction

  // Appends one slot; returns 0 when the FIFO is full.
  function automatic logic store_word(logic [DATA_W-1:0] pay, logic [DATA_W-1:0] stamp,
                                      logic mark);
    logic [IDX_W-1:0] idx;
    if (fill_now() >= DEPTH) return 1'b0;
    idx = wr_ptr[IDX_W-1:0];
    slot_payload[idx] = pay;
    slot_stamp[idx] = stamp;
    slot_eof[idx] = mark;
    wr_ptr = wr_ptr + 1'b1;
    return 1'b1;
  endfunction

  // Status of an attempt to queue an end-of-stream mark.
  function automatic scf_status_e queue_eof_mark();
    if (!mode_usable()) return ST_UNSUPPORTED;
    if (store_word('0, '0, 1'b1)) return ST_OK;
    return ST_EOF_NQ;
  endfunction

  // Applies one command word to the channel state and returns its result word.
  function automatic chan_result_t channel_step(logic [2:0] op, logic [DATA_W-1:0] pay,
                                                logic [DATA_W-1:0] stamp);
    chan_result_t r;
    logic [IDX_W-1:0] idx;
    r.status = ST_OK;
    r.ev = EV_NONE;
    r.payload = '0;
    r.stamp = '0;
    case (op)
      OP_PUT: begin
        if (!mode_usable()) r.status = ST_UNSUPPORTED;
        else if (!chan_open) r.status = ST_NOT_OPEN;
        else if (cancelled) r.status = ST_CANCELLED;
        else if (!store_word(pay, stamp, 1'b0)) begin
          if (cfg_block && cfg_finite) begin
            r.status = ST_RETRY;
          end else begin
            r.status = ST_DROPPED;
            if (drop_total != '1) drop_total = drop_total + 1'b1;
          end
        end
      end
      OP_POLL: begin
        if (!mode_usable()) begin
          r.status = ST_UNSUPPORTED;
          r.ev = EV_ERROR;
        end else if (fill_now() != 0) begin
          idx = rd_ptr[IDX_W-1:0];
          rd_ptr = rd_ptr + 1'b1;
          if (slot_eof[idx]) begin
            r.ev = EV_EOF;
          end else begin
            r.ev = EV_DATA;
            r.payload = slot_payload[idx];
            r.stamp = slot_stamp[idx];
          end
        end else if (cancelled && finished) r.ev = EV_DRAINED;
        else if (finished) r.ev = EV_EOF;
        else r.ev = EV_TIMEOUT;
      end
      OP_OPEN: begin
        if (!mode_usable()) begin
          r.status = ST_UNSUPPORTED;
        end else begin
          chan_open = 1'b1;
          finished = 1'b0;
          cancelled = 1'b0;
        end
      end
      OP_CLOSE: begin
        chan_open = 1'b0;
        finished = 1'b1;
      end
      OP_CLOSE_STREAM: begin
        if (!close_stream_done) begin
          close_stream_done = 1'b1;
          r.status = queue_eof_mark();
          finished = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (!cancel_done) begin
          cancel_done = 1'b1;
          cancelled = 1'b1;
          r.status = queue_eof_mark();
          finished = 1'b1;
        end
      end
      default: ;
    endcase
    r.fill = fill_now();
    r.drops = drop_total;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < 50)
      $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  // Every accepted command word yields one expected result word.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      pending_results.push_back(channel_step(in_ch.opcode, in_ch.payload, in_ch.timestamp));
  end

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin : check_results
    chan_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, status", 64'(out_ch.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", 64'(out_ch.status), 64'(want.status));
        if (out_ch.event_res !== want.ev)
          report_mismatch("event", 64'(out_ch.event_res), 64'(want.ev));
        if (out_ch.out_payload !== want.payload)
          report_mismatch("payload", out_ch.out_payload, want.payload);
        if (out_ch.out_timestamp !== want.stamp)
          report_mismatch("timestamp", out_ch.out_timestamp, want.stamp);
        if (out_ch.fill_level !== want.fill)
          report_mismatch("fill level", 64'(out_ch.fill_level), 64'(want.fill));
        if (out_ch.dropped_count !== want.drops)
          report_mismatch("drop count", 64'(out_ch.dropped_count), 64'(want.drops));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= dst_idle_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(9))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '0;
      default: return rand64();
    endcase
  endfunction

  // Offers one command word and returns at the falling edge after it is taken.
  task automatic send_word(logic [2:0] op, logic [63:0] pay, logic [63:0] stamp);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.payload = pay;
    in_ch.timestamp = stamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op);
    send_word(op, rand64(), rand64());
  endtask

  task automatic send_put(logic [63:0] pay, logic [63:0] stamp);
    send_word(OP_PUT, pay, stamp);
  endtask

  // Waits until every result word is back and the block has gone quiet.
  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write of one register, only while the block is idle.
  task automatic write_reg(logic [1:0] index, logic [31:0] value);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_CHAN_MODE:  cfg_mode = value[1:0];
      REG_BLOCK_FULL: cfg_block = value[0];
      REG_FINITE:     cfg_finite = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic pick_config();
    logic [1:0] mode;
    if ($urandom_range(9) < 8) mode = $urandom_range(1) ? MODE_MULTI_CONS : MODE_SINGLE;
    else mode = 2'($urandom_range(3));
    write_reg(REG_CHAN_MODE, {30'd0, mode});
    write_reg(REG_BLOCK_FULL, $urandom_range(1));
    write_reg(REG_FINITE, $urandom_range(1));
  endtask

  // Timeout, poll results on an empty and closed channel, extremes of the
  // data fields, unknown opcodes and an end-of-stream mark behind data.
  task automatic test_basic();
    send_op(OP_POLL);
    send_put(rand64(), rand64());
    send_op(3'd6);
    send_op(3'd7);
    send_op(OP_OPEN);
    send_put('1, 64'h7fff_ffff_ffff_ffff);
    send_put('0, 64'h8000_0000_0000_0000);
    send_put(rand64(), rand64());
    repeat (2) send_op(OP_POLL);
    send_op(OP_CLOSE_STREAM);
    send_put(rand64(), rand64());
    repeat (4) send_op(OP_POLL);
    send_op(OP_CLOSE_STREAM);
    send_op(OP_CLOSE);
    send_put(rand64(), rand64());
    send_op(OP_OPEN);
    send_op(OP_POLL);
  endtask

  // Unsupported ring modes refuse put, poll and open; close still acts.
  task automatic test_unsupported_modes();
    write_reg(REG_CHAN_MODE, 32'd3);
    send_put(rand64(), rand64());
    send_op(OP_POLL);
    send_op(OP_OPEN);
    send_op(OP_CLOSE_STREAM);
    write_reg(REG_CHAN_MODE, 32'd1);
    send_put(rand64(), rand64());
    send_op(OP_CLOSE);
    write_reg(REG_CHAN_MODE, {30'd0, MODE_MULTI_CONS});
    send_op(OP_OPEN);
    send_put(rand64(), rand64());
    send_op(OP_POLL);
    write_reg(REG_CHAN_MODE, {30'd0, MODE_SINGLE});
  endtask

  // Full FIFO under drop and block policy, then a cancel whose mark finds
  // no room, followed by a drain after cancel.
  task automatic test_full_fifo();
    repeat (DEPTH) send_put(rand_payload(), rand_stamp());
    send_put(rand64(), rand64());
    write_reg(REG_BLOCK_FULL, 32'd1);
    send_put(rand64(), rand64());
    write_reg(REG_FINITE, 32'd0);
    send_put(rand64(), rand64());
    write_reg(REG_FINITE, 32'd1);
    send_op(OP_CANCEL);
    send_put(rand64(), rand64());
    repeat (DEPTH + 1) send_op(OP_POLL);
    send_op(OP_CANCEL);
    send_op(OP_OPEN);
    send_op(OP_POLL);
    write_reg(REG_BLOCK_FULL, 32'd0);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_receiver_stall();
    src_idle_pct = 0;
    dst_idle_pct = 0;
    if (!chan_open || cancelled) send_op(OP_OPEN);
    hold_left = 80;
    repeat (20) begin
      if ($urandom_range(2) != 0) send_put(rand_payload(), rand_stamp());
      else send_op(OP_POLL);
    end
    wait_drained();
  endtask

  // Bursts of puts and polls with a random lean, some control words and noise.
  task automatic test_random_traffic(int src_pct, int dst_pct, int items);
    int sent;
    int lean;
    int burst;
    src_idle_pct = src_pct;
    dst_idle_pct = dst_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(3) == 0) pick_config();
      lean = $urandom_range(20, 80);
      burst = $urandom_range(10, 40);
      if ((!chan_open || cancelled) && $urandom_range(9) != 0) begin
        send_op(OP_OPEN);
        sent++;
      end
      repeat (burst) begin
        if ($urandom_range(99) < 4) send_op(3'($urandom_range(2, 7)));
        else if ($urandom_range(99) < lean) send_put(rand_payload(), rand_stamp());
        else send_op(OP_POLL);
      end
      sent += burst;
    end
    wait_drained();
  endtask

  // Run limit.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Test sequence.
  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PUT;
    in_ch.payload = '0;
    in_ch.timestamp = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_basic();
    test_unsupported_modes();
    test_full_fifo();
    test_receiver_stall();
    test_random_traffic(25, 72, 350);
    test_random_traffic(72, 25, 350);
    test_random_traffic(0, 0, 300);
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: stream_channel_fifo_unit.f
src/scf_pkg.sv
src/scf_if.sv
src/scf_regs.sv
src/scf_ctrl.sv
src/scf_dp.sv
src/stream_channel_fifo_unit.sv
verif/stream_channel_fifo_unit_tb.sv
